/* rtl/rpn_pkg.sv */
// Package: opcodes, status codes, controller states and control structs for the RPN calculator.
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_STEPS   = 32 + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_NEG   = 4'd5,
    OP_DUP   = 4'd6,
    OP_SWAP  = 4'd7,
    OP_PEEK  = 4'd8,
    OP_CLEAR = 4'd9,
    OP_DUMP  = 4'd10
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_FEW  = 3'd1,
    ST_DIV0 = 3'd2,
    ST_FULL = 3'd3,
    ST_BAD  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_TOP,
    S_RD_SEC,
    S_WAIT,
    S_EXEC,
    S_MUL2,
    S_DIV,
    S_DIV_FIN,
    S_WRITE,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       latch_in;   // capture opcode / push value
    logic       rd_top;     // read address = count-1
    logic       rd_sec;     // read address = count-2
    logic       rd_dump;    // read address = dump pointer
    logic       cap_b;      // capture read data as top operand
    logic       cap_a;      // capture read data as second operand
    logic       exec;       // compute add/sub/neg/mul stage 1, setup division
    logic       mul2;       // shift and saturate product
    logic       div_step;   // one restoring division step
    logic       div_fin;    // sign and saturate quotient
    logic       write;      // commit result to stack and count
    logic       dump_init;  // load dump pointer
    logic       dump_emit;  // emit one dump entry
    logic       emit_stat;  // emit status result
    status_t    stat;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_t        op;
    logic           bad_op;
    logic [CNT_W-1:0] count;
    logic           b_zero;
    logic           div_done;
    logic           dump_last;
  } dp_stat_t;

endpackage

/* rtl/rpn_stack_calculator.sv */
// Top level: RPN stack calculator on signed Q16.16 values.
// Sequence: each non-dump op reads top and second, waits, then executes and writes
// back; mul adds a shift step, div runs 48 restoring steps and a sign step; dump
// reads and emits each entry in turn; errors are reported from the execute state.
// One item at a time; busy holds until the last result is strobed.
// The single read port of the stack memory and the serial divider set this sequence.
// Reset (rst, synchronous): stack empty, controller idle; entries stay undefined.
module rpn_stack_calculator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] push_value,
  output logic               result_strobe,
  output logic signed [31:0] result_value,
  output logic               value_valid,
  output logic [2:0]         status,
  output logic [4:0]         entries_now,
  output logic               last_result
);
  import rpn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  // sequencer
  rpn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // stack, ALU, divider, result registers
  rpn_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .opcode        (opcode),
    .push_value    (push_value),
    .cmd           (cmd),
    .st            (st),
    .result_strobe (result_strobe),
    .result_value  (result_value),
    .value_valid   (value_valid),
    .status        (status),
    .entries_now   (entries_now),
    .last_result   (last_result)
  );

endmodule

/* rtl/rpn_datapath.sv */
// Datapath: stack memory, operand registers, ALU, serial divider and result registers.
module rpn_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [3:0]              opcode,
  input  logic signed [31:0]      push_value,
  input  rpn_pkg::dp_cmd_t        cmd,
  output rpn_pkg::dp_stat_t       st,
  output logic                    result_strobe,
  output logic signed [31:0]      result_value,
  output logic                    value_valid,
  output logic [2:0]              status,
  output logic [4:0]              entries_now,
  output logic                    last_result
);
  import rpn_pkg::*;

  logic [31:0]      mem [STACK_DEPTH];
  logic [31:0]      rd_data;
  logic [PTR_W-1:0] rd_addr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [3:0]       op_q;
  logic [31:0]      pv_q;
  logic signed [31:0] a, b;
  logic signed [31:0] res;
  logic signed [63:0] prod;
  logic [PTR_W-1:0] dptr;
  // divider
  logic [31:0]      dvsr;
  logic [DIV_STEPS-1:0] quo;
  logic [32:0]      rem;
  logic             q_neg;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [32:0]      rem_sh;
  logic [32:0]      rem_sub;
  // swap writes the top slot in the cycle after the second slot
  logic             swap_hi;

  // read address select
  always_comb begin
    rd_addr = dptr;
    if (cmd.rd_top) rd_addr = PTR_W'(count - CNT_W'(1));
    else if (cmd.rd_sec) rd_addr = PTR_W'(count - CNT_W'(2));
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  assign rem_sh  = {rem[31:0], quo[DIV_STEPS-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q <= opcode;
      pv_q <= push_value;
    end
    if (cmd.cap_b) b <= rd_data;
    if (cmd.cap_a) a <= rd_data;
    if (cmd.dump_init) dptr <= PTR_W'(count - CNT_W'(1));
    else if (cmd.dump_emit) dptr <= dptr - PTR_W'(1);
    if (cmd.exec) begin
      unique case (opcode_t'(op_q))
        OP_ADD:  res <= sat64(64'(a) + 64'(b));
        OP_SUB:  res <= sat64(64'(a) - 64'(b));
        OP_NEG:  res <= sat64(-64'(b));
        default: res <= b;
      endcase
      prod  <= a * b;
      q_neg <= a[31] ^ b[31];
      dvsr  <= b[31] ? 32'(-b) : 32'(b);
      quo   <= {(a[31] ? 32'(-a) : 32'(a)), {FRAC_BITS{1'b0}}};
      rem   <= '0;
      dcnt  <= '0;
    end
    if (cmd.mul2) res <= sat64(prod >>> FRAC_BITS);
    if (cmd.div_step) begin
      if (!rem_sub[32]) begin
        rem <= rem_sub;
        quo <= {quo[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DIV_STEPS-2:0], 1'b0};
      end
      dcnt <= dcnt + DIV_CNT_W'(1);
    end
    if (cmd.div_fin)
      res <= sat64(q_neg ? -$signed({16'd0, quo}) : $signed({16'd0, quo}));
  end

  always_ff @(posedge clk) begin
    if (rst) swap_hi <= 1'b0;
    else swap_hi <= cmd.write && opcode_t'(op_q) == OP_SWAP;
  end

  // stack write: one slot per cycle, swap finishes on the following cycle
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      unique case (opcode_t'(op_q))
        OP_PUSH: mem[PTR_W'(count)] <= pv_q;
        OP_DUP:  mem[PTR_W'(count)] <= b;
        OP_NEG:  mem[PTR_W'(count - CNT_W'(1))] <= res;
        OP_SWAP: begin
          mem[PTR_W'(count - CNT_W'(2))] <= b;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: mem[PTR_W'(count - CNT_W'(2))] <= res;
        default: ;
      endcase
    end
    if (swap_hi) mem[PTR_W'(count - CNT_W'(1))] <= a;
  end

  always_comb begin
    count_next = count;
    if (cmd.write) begin
      unique case (opcode_t'(op_q))
        OP_PUSH, OP_DUP:                 count_next = count + CNT_W'(1);
        OP_ADD, OP_SUB, OP_MUL, OP_DIV:  count_next = count - CNT_W'(1);
        OP_CLEAR:                        count_next = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else count <= count_next;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      last_result   <= 1'b0;
      value_valid   <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_stat | cmd.dump_emit;
      last_result   <= cmd.emit_stat | (cmd.dump_emit & (dptr == '0));
      value_valid   <= cmd.dump_emit | (cmd.emit_stat & (op_q == OP_PEEK)
                       & (cmd.stat == ST_OK));
    end
    result_value <= cmd.dump_emit ? rd_data :
                    ((op_q == OP_PEEK && cmd.stat == ST_OK) ? b : 32'd0);
    status       <= cmd.dump_emit ? ST_OK : cmd.stat;
    entries_now  <= 5'(count_next);
  end

  assign st.op        = opcode_t'(op_q);
  assign st.bad_op    = op_q > OP_DUMP;
  assign st.count     = count;
  assign st.b_zero    = (b == 32'sd0);
  assign st.div_done  = (dcnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign st.dump_last = (dptr == '0);

endmodule

/* rtl/rpn_ctrl.sv */
// Controller: sequences each item through operand reads, execution, write-back and results.
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rpn_pkg::dp_stat_t st,
  output rpn_pkg::dp_cmd_t  cmd
);
  import rpn_pkg::*;

  state_t state, state_next;
  status_t stat, stat_next;
  logic two, one, full;

  assign two  = st.count >= CNT_W'(2);
  assign one  = st.count >= CNT_W'(1);
  assign full = st.count >= CNT_W'(STACK_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stat  <= ST_OK;
    end else begin
      state <= state_next;
      stat  <= stat_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    stat_next  = stat;
    unique case (state)
      S_IDLE:    if (start) begin
        state_next = S_RD_TOP;
        stat_next  = ST_OK;
      end
      S_RD_TOP: begin
        state_next = S_RD_SEC;
        if (st.bad_op) stat_next = ST_BAD;
        else begin
          unique case (st.op)
            OP_PUSH: if (full) stat_next = ST_FULL;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: if (!two) stat_next = ST_FEW;
            OP_NEG, OP_PEEK: if (!one) stat_next = ST_FEW;
            OP_DUP: if (!one) stat_next = ST_FEW; else if (full) stat_next = ST_FULL;
            OP_DUMP: if (one) state_next = S_DUMP_RD;
            default: ;
          endcase
        end
      end
      S_RD_SEC:  state_next = S_WAIT;
      S_WAIT:    state_next = S_EXEC;
      S_EXEC: begin
        if (stat != ST_OK) state_next = S_IDLE;
        else if (st.op == OP_MUL) state_next = S_MUL2;
        else if (st.op == OP_DIV) begin
          if (st.b_zero) begin
            stat_next  = ST_DIV0;
            state_next = S_IDLE;
          end else state_next = S_DIV;
        end else state_next = S_WRITE;
      end
      S_MUL2:    state_next = S_WRITE;
      S_DIV:     if (st.div_done) state_next = S_DIV_FIN;
      S_DIV_FIN: state_next = S_WRITE;
      S_WRITE:   state_next = S_IDLE;
      S_DUMP_RD: state_next = S_DUMP_OUT;
      S_DUMP_OUT: state_next = st.dump_last ? S_IDLE : S_DUMP_RD;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    cmd.stat = stat;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:    cmd.latch_in = start;
      S_RD_TOP:  begin
        cmd.rd_top = 1'b1;
        cmd.dump_init = 1'b1;
      end
      S_RD_SEC:  begin
        cmd.rd_sec = 1'b1;
        cmd.cap_b  = 1'b1;
      end
      S_WAIT:    cmd.cap_a = 1'b1;
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat != ST_OK || (st.op == OP_DIV && st.b_zero)) begin
          cmd.emit_stat = 1'b1;
          if (st.op == OP_DIV && st.b_zero && stat == ST_OK) cmd.stat = ST_DIV0;
        end
      end
      S_MUL2:    cmd.mul2 = 1'b1;
      S_DIV:     cmd.div_step = 1'b1;
      S_DIV_FIN: cmd.div_fin = 1'b1;
      S_WRITE: begin
        cmd.write = 1'b1;
        cmd.emit_stat = 1'b1;
      end
      S_DUMP_RD: cmd.rd_dump = 1'b1;
      S_DUMP_OUT: cmd.dump_emit = 1'b1;
      default: ;
    endcase
  end

endmodule

/* dv/rpn_stack_calculator_tb.sv */
// Testbench for rpn_stack_calculator: directed table, a fill-to-full run, then random opcode streams, all self-checked.
`timescale 1ns / 1ps
module rpn_stack_calculator_tb;
  import rpn_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 80;   // longer than the slowest item (divide)

  // A row of the directed table: chk marks rows whose result is typed in.
  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] val;
    logic               chk;
    logic signed [31:0] x_val;
    logic               x_valid;
    status_t            x_stat;
    logic [4:0]         x_cnt;
  } step_row_t;

  typedef struct {
    logic signed [31:0] val;
    logic               valid;
    logic [2:0]         stat;
    logic [4:0]         cnt;
    logic               last;
  } calc_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         opcode = '0;
  logic signed [31:0] push_value = '0;
  logic               result_strobe;
  logic signed [31:0] result_value;
  logic               value_valid;
  logic [2:0]         status;
  logic [4:0]         entries_now;
  logic               last_result;

  rpn_stack_calculator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .push_value(push_value),
    .result_strobe(result_strobe), .result_value(result_value),
    .value_valid(value_valid), .status(status),
    .entries_now(entries_now), .last_result(last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: our own copy of the stack.
  logic signed [31:0] calc_stack [STACK_DEPTH];
  int                 calc_depth;
  calc_result_t       pending_results[$];
  int                 error_count = 0;
  int                 cycle_count = 0;

  function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic calc_result_t status_item(status_t s);
    calc_result_t r;
    r.val = '0; r.valid = 1'b0; r.stat = s; r.cnt = calc_depth[4:0]; r.last = 1'b1;
    return r;
  endfunction

  // Apply one opcode to the predictor stack and queue its results.
  task automatic predict_calc(logic [3:0] op, logic signed [31:0] pv);
    logic signed [65:0] a, b, r;
    calc_result_t       e;
    status_t            s;
    s = ST_OK;
    case (op)
      OP_PUSH: begin
        if (calc_depth >= STACK_DEPTH) s = ST_FULL;
        else begin
          calc_stack[calc_depth] = pv;
          calc_depth++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
        if (calc_depth < 2) s = ST_FEW;
        else begin
          a = calc_stack[calc_depth-2];
          b = calc_stack[calc_depth-1];
          if (op == OP_SWAP) begin
            calc_stack[calc_depth-2] = b[31:0];
            calc_stack[calc_depth-1] = a[31:0];
          end else if (op == OP_DIV && b == 0) begin
            s = ST_DIV0;
          end else begin
            case (op)
              OP_ADD: r = a + b;
              OP_SUB: r = a - b;
              OP_MUL: r = (a * b) >>> FRAC_BITS;  // floor shift
              default: r = (a <<< FRAC_BITS) / b;  // truncates toward zero
            endcase
            calc_stack[calc_depth-2] = clamp32(r);
            calc_depth--;
          end
        end
      end
      OP_NEG: begin
        if (calc_depth < 1) s = ST_FEW;
        else begin
          a = calc_stack[calc_depth-1];
          calc_stack[calc_depth-1] = clamp32(-a);
        end
      end
      OP_DUP: begin
        if (calc_depth < 1) s = ST_FEW;
        else if (calc_depth >= STACK_DEPTH) s = ST_FULL;
        else begin
          calc_stack[calc_depth] = calc_stack[calc_depth-1];
          calc_depth++;
        end
      end
      OP_PEEK: begin
        if (calc_depth < 1) s = ST_FEW;
        else begin
          e = status_item(ST_OK);
          e.val = calc_stack[calc_depth-1];
          e.valid = 1'b1;
          pending_results.push_back(e);
          return;
        end
      end
      OP_CLEAR: calc_depth = 0;
      OP_DUMP: begin
        if (calc_depth > 0) begin
          for (int i = calc_depth; i > 0; i--) begin
            e = status_item(ST_OK);
            e.val = calc_stack[i-1];
            e.valid = 1'b1;
            e.last = (i == 1);
            pending_results.push_back(e);
          end
          return;
        end
      end
      default: s = ST_BAD;
    endcase
    pending_results.push_back(status_item(s));
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Result checker: results cannot be held off, so every strobe is taken.
  always @(posedge clk) begin
    calc_result_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && result_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = pending_results.pop_front();
        if (result_value !== e.val) report_mismatch("result_value", result_value, e.val);
        if (value_valid !== e.valid) report_mismatch("value_valid", value_valid, e.valid);
        if (status !== e.stat) report_mismatch("status", status, e.stat);
        if (entries_now !== e.cnt) report_mismatch("entries_now", entries_now, e.cnt);
        if (last_result !== e.last) report_mismatch("last_result", last_result, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Present one item at the falling edge and hold until accepted.
  task automatic send_item(logic [3:0] op, logic signed [31:0] pv);
    @(negedge clk);
    while (busy) @(negedge clk);
    opcode <= op;
    push_value <= pv;
    start <= 1'b1;
    @(posedge clk);
    predict_calc(op, pv);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic idle_gap(int n);
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;  // near +-2.0
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] rand_op(int depth);
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return 4'($urandom_range(11, 15));        // noise
    if (p < 8) return OP_CLEAR;
    if (p < 12) return OP_DUMP;
    if (depth < 2 && p < 60) return OP_PUSH;
    if (depth >= STACK_DEPTH - 1 && p < 30) return OP_ADD;
    if (p < 35) return OP_PUSH;
    return 4'($urandom_range(OP_ADD, OP_PEEK));
  endfunction

  step_row_t directed[$];

  initial begin
    step_row_t row;
    logic [3:0] op;
    calc_depth = 0;
    foreach (calc_stack[i]) calc_stack[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Checked rows: short-stack and divide-by-zero errors, bad opcode, extremes.
    directed = '{
      '{OP_DUMP,  0, 1, 0, 0, ST_OK,   0},   // empty dump
      '{OP_ADD,   0, 1, 0, 0, ST_FEW,  0},
      '{OP_NEG,   0, 1, 0, 0, ST_FEW,  0},
      '{OP_DUP,   0, 1, 0, 0, ST_FEW,  0},   // few wins over full check
      '{OP_PEEK,  0, 1, 0, 0, ST_FEW,  0},
      '{4'd15,    0, 1, 0, 0, ST_BAD,  0},
      '{OP_PUSH,  32'sh7fffffff, 1, 0, 0, ST_OK, 1},
      '{OP_PEEK,  0, 1, 32'sh7fffffff, 1, ST_OK, 1},
      '{OP_SWAP,  0, 1, 0, 0, ST_FEW,  1},
      '{OP_PUSH,  32'sh7fffffff, 0, 0, 0, ST_OK, 0},
      '{OP_ADD,   0, 0, 0, 0, ST_OK, 0},     // saturates high
      '{OP_PUSH,  32'sh80000000, 0, 0, 0, ST_OK, 0},
      '{OP_NEG,   0, 0, 0, 0, ST_OK, 0},     // negate of min saturates
      '{OP_PUSH,  32'sh80000000, 0, 0, 0, ST_OK, 0},
      '{OP_SUB,   0, 0, 0, 0, ST_OK, 0},
      '{OP_PUSH,  32'sh00030000, 0, 0, 0, ST_OK, 0},
      '{OP_MUL,   0, 0, 0, 0, ST_OK, 0},
      '{OP_PUSH,  32'sh0, 0, 0, 0, ST_OK, 0},
      '{OP_DIV,   0, 1, 0, 0, ST_DIV0, 3},
      '{OP_PUSH,  32'shfffe8000, 0, 0, 0, ST_OK, 0},
      '{OP_SWAP,  0, 0, 0, 0, ST_OK, 0},
      '{OP_DIV,   0, 0, 0, 0, ST_OK, 0},
      '{OP_DUP,   0, 0, 0, 0, ST_OK, 0},
      '{OP_DUMP,  0, 0, 0, 0, ST_OK, 0},
      '{OP_CLEAR, 0, 1, 0, 0, ST_OK, 0}
    };
    foreach (directed[i]) begin
      row = directed[i];
      send_item(row.op, row.val);
      if (row.chk) begin
        // typed-in expectation must agree with the predictor's last entry
        if (pending_results[$].val !== row.x_val || pending_results[$].valid !== row.x_valid ||
            pending_results[$].stat !== row.x_stat || pending_results[$].cnt !== row.x_cnt)
          report_mismatch("directed row", i, i);
      end
    end

    // Fill to full, hit stack full on push and dup, dump all 16.
    for (int i = 0; i < STACK_DEPTH + 1; i++) send_item(OP_PUSH, $urandom());
    send_item(OP_DUP, 0);
    send_item(OP_DUMP, 0);

    // Pause until every result has drained.
    while (pending_results.size() != 0) @(negedge clk);
    idle_gap(TAIL_CYCLES);

    // Random part: bursts with gaps.
    for (int n = 0; n < 150; ) begin
      int burst;
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < 150; k++, n++) begin
        op = rand_op(calc_depth);
        send_item(op, rand_value());
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(0, 3));
      end
      if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 40));
    end

    while (pending_results.size() != 0) @(negedge clk);
    idle_gap(TAIL_CYCLES);
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

/* rpn_stack_calculator.f */
rtl/rpn_pkg.sv
rtl/rpn_datapath.sv
rtl/rpn_ctrl.sv
rtl/rpn_stack_calculator.sv
dv/rpn_stack_calculator_tb.sv
